// ===== hdl/srec_ihex_data_extractor_unit_macros.svh =====
// ----------------------------------------------------------------------------
// srec_ihex_data_extractor_unit_macros
// assertion macros shared by the record parser files
// ----------------------------------------------------------------------------
`ifndef SREC_IHEX_DATA_EXTRACTOR_UNIT_MACROS_SVH
`define SREC_IHEX_DATA_EXTRACTOR_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk_i, held off during reset
`define SREC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srec assertion failed");

// next-cycle implication, clocked on clk_i, held off during reset
`define SREC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srec assertion failed");

`endif

// ===== hdl/srec_pkg.sv =====
// ----------------------------------------------------------------------------
// srec_pkg
// shared types, character codes and hex digit helpers for the record parser
// ----------------------------------------------------------------------------
`default_nettype none

package srec_pkg;

  localparam int unsigned PosW = 10;
  localparam logic [PosW-1:0] POS_MAX = '1;

  // character codes
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_THREE   = 8'h33;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_F    = 8'h46;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_F    = 8'h66;
  localparam logic [7:0] CH_UP_S    = 8'h53;

  // record kind codes
  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_S1       = 3'd1;
  localparam logic [2:0] KIND_S3       = 3'd3;
  localparam logic [2:0] KIND_HEX_DATA = 3'd4;

  // format register codes
  localparam logic FMT_SREC = 1'b0;
  localparam logic FMT_IHEX = 1'b1;

  // result kind codes
  localparam logic RES_BYTE    = 1'b0;
  localparam logic RES_DISCARD = 1'b1;

  // word held in the input stage
  typedef struct packed {
    logic       vld;
    logic [7:0] code;
  } stage_t;

  // result word from the parser
  typedef struct packed {
    logic       vld;
    logic       kind;
    logic [7:0] data;
  } result_t;

  // {bad, value}
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LO_A && c <= CH_LO_F)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end
    return v;
  endfunction

  function automatic logic [3:0] high_digit(input logic [7:0] c);
    logic [4:0] v;
    v = digit_value(c);
    return v[4] ? 4'hF : v[3:0];
  endfunction

  function automatic logic [7:0] make_byte(input logic [3:0] hi, input logic [7:0] c);
    logic [4:0] v;
    v = digit_value(c);
    return v[4] ? 8'hFF : {hi, v[3:0]};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/srec_ihex_data_extractor_unit.sv =====
// ----------------------------------------------------------------------------
// srec_ihex_data_extractor_unit
// payload byte extractor for s-record and intel hex text
// ----------------------------------------------------------------------------
// usage
//   input channel: one character word per handshake on char_code_i, taken at
//   a rising edge with in_valid_i high and in_stall_o low. a newline ends a
//   record line.
//   output channel: zero or one result word per character, on result_kind_o
//   (0 data byte, 1 discard mark from an s0 record) and payload_byte_o,
//   taken when out_valid_o is high and out_stall_i is low.
//   configuration: cfg_wr_en_i writes cfg_wr_data_i to the format register
//   (0 s-record, 1 intel hex); write only between lines or while idle.
// timing
//   one character per cycle sustained while the output is not stalled; the
//   parser is a single registered pass from the input stage to the result
//   register, after the character is first held in the input stage.
// reset
//   clears the line state, the format register (s-record) and both stages.
// stall
//   a stalled result holds; the input stage stalls only once it holds a word
//   that cannot move into the occupied result register.
// ----------------------------------------------------------------------------
`default_nettype none

module srec_ihex_data_extractor_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_wr_en_i,
  input  wire logic       cfg_wr_data_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] char_code_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            result_kind_o,
  output logic [7:0]      payload_byte_o
);
  import srec_pkg::*;
  `include "srec_ihex_data_extractor_unit_macros.svh"

  stage_t  stage;
  result_t result;
  logic    out_ready;
  logic    advance;

  // the held character moves on whenever the result register has room
  assign advance = stage.vld && out_ready;

  srec_char_stage u_char_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .advance_i   (advance),
    .stage_o     (stage)
  );

  // line decode and format register
  srec_parse_core u_parse_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .advance_i     (advance),
    .stage_i       (stage),
    .result_o      (result)
  );

  srec_out_stage u_out_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .result_i       (result),
    .load_i         (advance),
    .ready_o        (out_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .payload_byte_o (payload_byte_o)
  );

  `SREC_ASSERT_NOW(a_discard_zero, out_valid_o && result_kind_o == RES_DISCARD, payload_byte_o == 8'd0)
  `SREC_ASSERT_NOW(a_stall_cause, in_stall_o, stage.vld && out_valid_o && out_stall_i)
  `SREC_ASSERT_NOW(a_out_from_stage, out_valid_o && !$past(out_valid_o), $past(stage.vld))

endmodule

`default_nettype wire

// ===== hdl/srec_char_stage.sv =====
// ----------------------------------------------------------------------------
// srec_char_stage
// input register holding one character word ahead of the parser
// ----------------------------------------------------------------------------
`default_nettype none

module srec_char_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic [7:0]     char_code_i,
  input  wire logic           advance_i,
  output srec_pkg::stage_t    stage_o
);
  import srec_pkg::*;

  logic       vld_q, vld_d;
  logic [7:0] code_q, code_d;
  logic       accept;

  // stall only while a held word cannot move on
  assign in_stall_o = vld_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d  = vld_q;
    code_d = code_q;
    if (accept) begin
      vld_d  = 1'b1;
      code_d = char_code_i;
    end else if (advance_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  assign stage_o = '{vld: vld_q, code: code_q};

endmodule

`default_nettype wire

// ===== hdl/srec_parse_core.sv =====
// ----------------------------------------------------------------------------
// srec_parse_core
// line state and format register, one character decoded per advance
// ----------------------------------------------------------------------------
`default_nettype none

module srec_parse_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_wr_en_i,
  input  wire logic           cfg_wr_data_i,
  input  wire logic           advance_i,
  input  srec_pkg::stage_t    stage_i,
  output srec_pkg::result_t   result_o
);
  import srec_pkg::*;
  `include "srec_ihex_data_extractor_unit_macros.svh"

  logic            fmt_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic [2:0]      kind_q, kind_d;
  logic [7:0]      count_q, count_d;
  logic [3:0]      hi_q, hi_d;
  logic [7:0]      left_q, left_d;
  logic [7:0]      first_q, first_d;

  logic [7:0]      c;
  logic [7:0]      mb;
  logic [7:0]      addr_ck;
  logic [PosW-1:0] start;
  logic            srec_kind;

  assign c         = stage_i.code;
  assign mb        = make_byte(hi_q, c);
  assign srec_kind = (kind_q >= KIND_S1) && (kind_q <= KIND_S3);
  // address bytes plus checksum
  assign addr_ck   = {5'd0, kind_q} + 8'd2;
  assign start     = {{(PosW-4){1'b0}}, kind_q, 1'b0} + PosW'(6);

  always_comb begin
    pos_d    = pos_q;
    kind_d   = kind_q;
    count_d  = count_q;
    hi_d     = hi_q;
    left_d   = left_q;
    first_d  = first_q;
    result_o = '0;
    if (c == CH_NEWLINE) begin
      pos_d   = '0;
      kind_d  = KIND_NONE;
      count_d = '0;
      hi_d    = '0;
      left_d  = '0;
      first_d = '0;
    end else begin
      if (pos_q != POS_MAX) begin
        pos_d = pos_q + PosW'(1);
      end
      if (fmt_q == FMT_SREC) begin
        if (pos_q == PosW'(0)) begin
          first_d = c;
        end else if (pos_q == PosW'(1)) begin
          kind_d = KIND_NONE;
          if (first_q == CH_UP_S) begin
            if (c == CH_ZERO) begin
              result_o = '{vld: 1'b1, kind: RES_DISCARD, data: 8'd0};
            end else if (c >= CH_ONE && c <= CH_THREE) begin
              kind_d = c[2:0];
            end
          end
        end else if (pos_q == PosW'(2)) begin
          hi_d = high_digit(c);
        end else if (pos_q == PosW'(3)) begin
          count_d = mb;
          if (srec_kind && mb > addr_ck) begin
            left_d = mb - addr_ck;
          end else begin
            left_d = '0;
          end
        end else if (srec_kind && left_q != 8'd0 && pos_q >= start) begin
          // data start is even, so the low bit picks the digit
          if (!pos_q[0]) begin
            hi_d = high_digit(c);
          end else begin
            result_o = '{vld: 1'b1, kind: RES_BYTE, data: mb};
            left_d   = left_q - 8'd1;
          end
        end
      end else begin
        if (pos_q == PosW'(1)) begin
          hi_d = high_digit(c);
        end else if (pos_q == PosW'(2)) begin
          count_d = mb;
        end else if (pos_q == PosW'(7)) begin
          first_d = c;
        end else if (pos_q == PosW'(8)) begin
          if (first_q == CH_ZERO && c == CH_ZERO) begin
            kind_d = KIND_HEX_DATA;
            left_d = count_q;
          end else begin
            kind_d = KIND_NONE;
            left_d = '0;
          end
        end else if (pos_q >= PosW'(9) && kind_q == KIND_HEX_DATA && left_q != 8'd0) begin
          // data starts at an odd position
          if (pos_q[0]) begin
            hi_d = high_digit(c);
          end else begin
            result_o = '{vld: 1'b1, kind: RES_BYTE, data: mb};
            left_d   = left_q - 8'd1;
          end
        end
      end
    end
    if (!stage_i.vld) begin
      result_o.vld = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= FMT_SREC;
      pos_q   <= '0;
      kind_q  <= KIND_NONE;
      count_q <= '0;
      hi_q    <= '0;
      left_q  <= '0;
      first_q <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        fmt_q <= cfg_wr_data_i;
      end
      if (advance_i) begin
        pos_q   <= pos_d;
        kind_q  <= kind_d;
        count_q <= count_d;
        hi_q    <= hi_d;
        left_q  <= left_d;
        first_q <= first_d;
      end
    end
  end

  `SREC_ASSERT_NEXT(a_newline_restarts, advance_i && c == CH_NEWLINE, pos_q == '0 && left_q == '0)
  `SREC_ASSERT_NEXT(a_pos_saturates, advance_i && c != CH_NEWLINE && pos_q == POS_MAX, pos_q == POS_MAX)
  `SREC_ASSERT_NOW(a_byte_needs_left, result_o.vld && result_o.kind == RES_BYTE, left_q != 8'd0)

endmodule

`default_nettype wire

// ===== hdl/srec_out_stage.sv =====
// ----------------------------------------------------------------------------
// srec_out_stage
// result register towards the receiver, reloads as the old word is taken
// ----------------------------------------------------------------------------
`default_nettype none

module srec_out_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  srec_pkg::result_t   result_i,
  input  wire logic           load_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic                result_kind_o,
  output logic [7:0]          payload_byte_o
);
  import srec_pkg::*;

  logic       vld_q, vld_d;
  logic       kind_q, kind_d;
  logic [7:0] data_q, data_d;

  assign ready_o = !vld_q || !out_stall_i;

  always_comb begin
    vld_d  = vld_q;
    kind_d = kind_q;
    data_d = data_q;
    if (load_i && result_i.vld) begin
      vld_d  = 1'b1;
      kind_d = result_i.kind;
      data_d = result_i.data;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    data_q <= data_d;
  end

  assign out_valid_o    = vld_q;
  assign result_kind_o  = kind_q;
  assign payload_byte_o = data_q;

endmodule

`default_nettype wire
